/* rtl/bgic_pkg.sv */
// ----------------------------------------------------------------------------
// Binary grid island counter package
// Shared constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package bgic_pkg;

  // Default grid limits.
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Fixed field widths of the channels.
  localparam int SIZE_W  = 7;
  localparam int COUNT_W = 13;
  localparam int INDEX_W = 8;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_GRID_ROWS = 8'd0;
  localparam logic [INDEX_W-1:0] REG_GRID_COLS = 8'd1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CELL_RD,
    ST_CELL_CHK,
    ST_PICK,
    ST_NBR_RD,
    ST_NBR_CHK,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_COMP_RD,
    ST_COMP_CHK,
    ST_SIZE_A,
    ST_SIZE_B,
    ST_LINK,
    ST_ADV,
    ST_OUT
  } state_t;

endpackage

/* rtl/bgic_if.sv */
// ----------------------------------------------------------------------------
// Binary grid island counter channels
// Valid/ready channels for cell words, result words and register writes.
// ----------------------------------------------------------------------------
interface bgic_cell_if;
  logic valid;
  logic ready;
  logic cell_is_land;
  modport source (output valid, output cell_is_land, input ready);
  modport sink (input valid, input cell_is_land, output ready);
endinterface

interface bgic_result_if;
  logic                     valid;
  logic                     ready;
  logic [bgic_pkg::COUNT_W-1:0] island_count;
  modport source (output valid, output island_count, input ready);
  modport sink (input valid, input island_count, output ready);
endinterface

interface bgic_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bgic_pkg::INDEX_W-1:0] reg_index;
  logic [bgic_pkg::SIZE_W-1:0]  wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

/* rtl/bgic_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bgic_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/binary_grid_island_counter.sv */
// ----------------------------------------------------------------------------
// Binary grid island counter
// Counts 4-connected land regions of a grid loaded cell by cell.
// ----------------------------------------------------------------------------
// Cells arrive in raster order at one word per cycle while the block is
// loading; grid_rows times grid_cols words make a grid. While a cell loads,
// its parent link and tree size entries are set up at the same address, so
// no clearing pass is needed. Once the grid is complete the input is not
// ready while one sequencer walks the cell, parent and size memories, each
// with one read port: a water cell is read and passed over, a land cell
// checks its right and then its lower neighbour, and each merge takes two
// find walks, a compression write on each link walked, and a link by size.
// One result word follows; loading of the next grid starts once it is taken.
// Register writes are taken only while loading, and row and column writes
// restart the load; a pending register write holds off cell words that cycle.
module binary_grid_island_counter #(
  parameter int MAX_ROWS = bgic_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bgic_pkg::DEF_MAX_COLS
) (
  input logic           clk,
  input logic           rst,
  bgic_cell_if.sink     cells,
  bgic_result_if.source result,
  bgic_cfg_if.sink      cfg
);
  import bgic_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int KW    = $clog2(MAX_COLS + 1);

  state_t          state, state_next;
  logic [RW-1:0]   rows;
  logic [KW-1:0]   cols;
  logic [CW-1:0]   total;
  logic [CW-1:0]   ld;
  logic [CW-1:0]   land_cnt;
  logic [CW-1:0]   union_cnt;
  logic [AW-1:0]   idx, nbr, cur, start, root, ra;
  logic [RW-1:0]   row;
  logic [KW-1:0]   col;
  logic            dir_down;
  logic            second;
  logic [CW-1:0]   size_a;
  logic [31:0]     diff;

  logic            cell_we, cell_rdata;
  logic [AW-1:0]   cell_raddr;
  logic            par_we;
  logic [AW-1:0]   par_waddr, par_wdata, par_rdata;
  logic            size_we;
  logic [AW-1:0]   size_waddr, size_raddr;
  logic [CW-1:0]   size_wdata, size_rdata, size_sum;

  logic            acc, cfg_wr, last_load, col_last, row_last, link_a_to_b;
  logic [RW-1:0]   rows_clamp;
  logic [KW-1:0]   cols_clamp;

  // Memories.
  bgic_ram #(.WIDTH(1), .DEPTH(CELLS), .AW(AW)) u_cell_ram (
    .clk(clk), .we(cell_we), .waddr(ld[AW-1:0]), .wdata(cells.cell_is_land),
    .raddr(cell_raddr), .rdata(cell_rdata)
  );
  bgic_ram #(.WIDTH(AW), .DEPTH(CELLS), .AW(AW)) u_parent_ram (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(cur), .rdata(par_rdata)
  );
  bgic_ram #(.WIDTH(CW), .DEPTH(CELLS), .AW(AW)) u_size_ram (
    .clk(clk), .we(size_we), .waddr(size_waddr), .wdata(size_wdata),
    .raddr(size_raddr), .rdata(size_rdata)
  );

  // Handshakes and derived conditions.
  assign acc         = cells.valid && cells.ready;
  assign cfg_wr      = cfg.valid && cfg.ready;
  assign total       = CW'(32'(rows) * 32'(cols));
  assign last_load   = (ld + CW'(1)) == total;
  assign col_last    = (32'(col) + 32'd1) >= 32'(cols);
  assign row_last    = (32'(row) + 32'd1) >= 32'(rows);
  assign size_sum    = size_a + size_rdata;
  assign link_a_to_b = !(size_a > size_rdata);
  assign diff        = 32'(land_cnt) - 32'(union_cnt);

  // Size register clamping: zero reads as one, large values saturate.
  always_comb begin
    if (cfg.wdata == '0) begin
      rows_clamp = RW'(1);
      cols_clamp = KW'(1);
    end else begin
      rows_clamp = (32'(cfg.wdata) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(cfg.wdata);
      cols_clamp = (32'(cfg.wdata) > MAX_COLS) ? KW'(MAX_COLS) : KW'(cfg.wdata);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:     if (acc && last_load) state_next = ST_CELL_RD;
      ST_CELL_RD:  state_next = ST_CELL_CHK;
      ST_CELL_CHK: state_next = cell_rdata ? ST_PICK : ST_ADV;
      ST_PICK: begin
        if (!dir_down) begin
          state_next = col_last ? ST_PICK : ST_NBR_RD;
        end else begin
          state_next = row_last ? ST_ADV : ST_NBR_RD;
        end
      end
      ST_NBR_RD:   state_next = ST_NBR_CHK;
      ST_NBR_CHK: begin
        if (cell_rdata) begin
          state_next = ST_FIND_RD;
        end else begin
          state_next = dir_down ? ST_ADV : ST_PICK;
        end
      end
      ST_FIND_RD:  state_next = ST_FIND_CHK;
      ST_FIND_CHK: state_next = (par_rdata == cur) ? ST_COMP_RD : ST_FIND_RD;
      ST_COMP_RD:  state_next = ST_COMP_CHK;
      ST_COMP_CHK: begin
        if (par_rdata != root) begin
          state_next = ST_COMP_RD;
        end else if (!second) begin
          state_next = ST_FIND_RD;
        end else if (ra != root) begin
          state_next = ST_SIZE_A;
        end else begin
          state_next = dir_down ? ST_ADV : ST_PICK;
        end
      end
      ST_SIZE_A:   state_next = ST_SIZE_B;
      ST_SIZE_B:   state_next = ST_LINK;
      ST_LINK:     state_next = dir_down ? ST_ADV : ST_PICK;
      ST_ADV:      state_next = (col_last && row_last) ? ST_OUT : ST_CELL_RD;
      ST_OUT:      if (result.ready) state_next = ST_LOAD;
      default:     state_next = ST_LOAD;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    cells.ready  = (state == ST_LOAD) && !cfg.valid;
    result.valid = (state == ST_OUT);
    result.island_count = diff[COUNT_W-1:0];
    cfg.ready    = (state == ST_LOAD);
    cell_we      = acc;
    cell_raddr   = (state == ST_NBR_RD) ? nbr : idx;
    size_raddr   = (state == ST_SIZE_A) ? ra : root;
    par_we       = 1'b0;
    par_waddr    = ld[AW-1:0];
    par_wdata    = ld[AW-1:0];
    size_we      = 1'b0;
    size_waddr   = ld[AW-1:0];
    size_wdata   = CW'(1);
    case (state)
      ST_LOAD: begin
        par_we  = acc;
        size_we = acc;
      end
      ST_COMP_CHK: begin
        par_we    = (par_rdata != root);
        par_waddr = cur;
        par_wdata = root;
      end
      ST_LINK: begin
        par_we     = 1'b1;
        size_we    = 1'b1;
        par_waddr  = link_a_to_b ? ra : root;
        par_wdata  = link_a_to_b ? root : ra;
        size_waddr = link_a_to_b ? root : ra;
        size_wdata = size_sum;
      end
      default: begin
        par_we  = 1'b0;
        size_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      rows     <= RW'(MAX_ROWS);
      cols     <= KW'(MAX_COLS);
      ld       <= '0;
      land_cnt <= '0;
    end else begin
      state <= state_next;
      if (acc) begin
        ld       <= ld + CW'(1);
        land_cnt <= land_cnt + CW'(cells.cell_is_land);
      end
      if (state == ST_OUT && result.ready) begin
        ld       <= '0;
        land_cnt <= '0;
      end
      if (cfg_wr && (cfg.reg_index == REG_GRID_ROWS || cfg.reg_index == REG_GRID_COLS)) begin
        if (cfg.reg_index == REG_GRID_ROWS) begin
          rows <= rows_clamp;
        end else begin
          cols <= cols_clamp;
        end
        ld       <= '0;
        land_cnt <= '0;
      end
    end
  end

  // Scan and union-find working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      union_cnt <= '0;
      dir_down  <= 1'b0;
      second    <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          idx       <= '0;
          row       <= '0;
          col       <= '0;
          union_cnt <= '0;
        end
        ST_CELL_CHK: dir_down <= 1'b0;
        ST_PICK: begin
          if (!dir_down) begin
            nbr <= idx + AW'(1);
            if (col_last) begin
              dir_down <= 1'b1;
            end
          end else begin
            nbr <= idx + AW'(cols);
          end
        end
        ST_NBR_CHK: begin
          cur    <= idx;
          start  <= idx;
          second <= 1'b0;
          if (!cell_rdata) begin
            dir_down <= 1'b1;
          end
        end
        ST_FIND_CHK: begin
          if (par_rdata == cur) begin
            root <= cur;
            cur  <= start;
          end else begin
            cur <= par_rdata;
          end
        end
        ST_COMP_CHK: begin
          if (par_rdata != root) begin
            cur <= par_rdata;
          end else if (!second) begin
            ra     <= root;
            second <= 1'b1;
            start  <= nbr;
            cur    <= nbr;
          end else if (ra == root) begin
            dir_down <= 1'b1;
          end
        end
        ST_SIZE_B: size_a <= size_rdata;
        ST_LINK: begin
          union_cnt <= union_cnt + CW'(1);
          dir_down  <= 1'b1;
        end
        ST_ADV: begin
          idx <= idx + AW'(1);
          if (col_last) begin
            col <= '0;
            row <= row + RW'(1);
          end else begin
            col <= col + KW'(1);
          end
        end
        default: begin
          second <= second;
        end
      endcase
    end
  end

endmodule

/* rtl/bgic_checker.sv */
// ----------------------------------------------------------------------------
// Binary grid island counter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module bgic_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cells_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [bgic_pkg::COUNT_W-1:0]   island_count,
  input logic                           cfg_ready
);

  // No cell word is taken while a result waits.
  a_no_load_with_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !cells_ready) else $error("cell taken while result pending");

  // A waiting result holds its value.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(island_count))
    else $error("result dropped or changed");

  // Valid drops once a result word is taken.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready |=> !result_valid)
    else $error("result repeated");

  // The count never exceeds the cell capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> island_count <= 13'd4096) else $error("count out of range");

  // No register write is taken while a result waits.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !cfg_ready) else $error("register port open while busy");

endmodule

bind binary_grid_island_counter bgic_checker u_bgic_checker (
  .clk(clk),
  .rst(rst),
  .cells_ready(cells.ready),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .island_count(result.island_count),
  .cfg_ready(cfg.ready)
);

/* tb/sv/tb_binary_grid_island_counter.sv */
// ----------------------------------------------------------------------------
// Binary grid island counter testbench
// Feeds grids of cell words under several sizes, predicts the island count of
// each grid with a union-find of its own, and checks every result word while
// both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_binary_grid_island_counter;
  import bgic_pkg::*;

  localparam int CAP = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int STALL_LIMIT = 400000;

  logic clk;
  logic rst;

  bgic_cell_if   cells_ch ();
  bgic_result_if result_ch ();
  bgic_cfg_if    cfg_ch ();

  binary_grid_island_counter uut (
    .clk    (clk),
    .rst    (rst),
    .cells  (cells_ch.sink),
    .result (result_ch.source),
    .cfg    (cfg_ch.sink)
  );

  // Predictor state: grid size and the grid being loaded.
  int unsigned rows_q;
  int unsigned cols_q;
  int unsigned loaded_q;
  bit          grid_q [CAP];
  int unsigned link_q [CAP];
  int unsigned size_q [CAP];

  logic                land_words [$];
  logic [COUNT_W-1:0]  count_expected [$];
  int unsigned         failures;
  bit                  hold_result;
  bit                  driver_enable;

  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > DEF_MAX_ROWS) return DEF_MAX_ROWS;
    return v;
  endfunction

  function automatic int unsigned root_find(int unsigned x);
    int unsigned r;
    int unsigned nxt;
    r = x;
    while (link_q[r] != r) r = link_q[r];
    while (link_q[x] != r) begin
      nxt = link_q[x];
      link_q[x] = r;
      x = nxt;
    end
    return r;
  endfunction

  // Counts the islands of the loaded grid and queues the expected word.
  function automatic void predict_islands();
    int unsigned comps;
    int unsigned water;
    int unsigned idx;
    int unsigned ra;
    int unsigned rb;
    int unsigned nb;
    comps = rows_q * cols_q;
    water = 0;
    for (int i = 0; i < CAP; i++) begin
      link_q[i] = i;
      size_q[i] = 1;
    end
    for (int r = 0; r < rows_q; r++) begin
      for (int c = 0; c < cols_q; c++) begin
        idx = r * cols_q + c;
        if (!grid_q[idx]) begin
          water++;
          continue;
        end
        for (int k = 0; k < 2; k++) begin
          if (k == 0 && !(c + 1 < cols_q)) continue;
          if (k == 1 && !(r + 1 < rows_q)) continue;
          nb = (k == 0) ? idx + 1 : idx + cols_q;
          if (!grid_q[nb]) continue;
          ra = root_find(idx);
          rb = root_find(nb);
          if (ra == rb) continue;
          if (size_q[ra] > size_q[rb]) begin
            link_q[rb] = ra;
            size_q[ra] += size_q[rb];
          end else begin
            link_q[ra] = rb;
            size_q[rb] += size_q[ra];
          end
          comps--;
        end
      end
    end
    count_expected.push_back(COUNT_W'(comps - water));
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver of cell words; the predictor sees each word as it is accepted.
  int unsigned send_gap;
  always @(posedge clk) begin
    if (rst) begin
      cells_ch.valid <= 1'b0;
      cells_ch.cell_is_land <= 1'b0;
      send_gap = 0;
    end else begin
      if (cells_ch.valid && cells_ch.ready) begin
        grid_q[loaded_q] = cells_ch.cell_is_land;
        loaded_q++;
        if (loaded_q == rows_q * cols_q) begin
          predict_islands();
          loaded_q = 0;
        end
        void'(land_words.pop_front());
        send_gap = gap_len();
      end
      if (!(cells_ch.valid && !cells_ch.ready)) begin
        if (send_gap > 0) send_gap--;
        if (driver_enable && send_gap == 0 && land_words.size() > 0) begin
          cells_ch.valid <= 1'b1;
          cells_ch.cell_is_land <= land_words[0];
        end else begin
          cells_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver with random stalls.
  int unsigned recv_gap;
  logic [COUNT_W-1:0] want;
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (count_expected.size() == 0) begin
          $error("island_count: no word expected, actual %0d", result_ch.island_count);
          failures++;
        end else begin
          want = count_expected.pop_front();
          if (result_ch.island_count !== want) begin
            $error("island_count: expected %0d, actual %0d", want,
                   result_ch.island_count);
            failures++;
          end
        end
        recv_gap = gap_len();
      end
      if (recv_gap > 0) recv_gap--;
      result_ch.ready <= !hold_result && recv_gap == 0;
    end
  end

  // Watchdog on cycles without any accepted word.
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if (rst || (cells_ch.valid && cells_ch.ready) ||
        (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("binary_grid_island_counter verification failed");
        $finish;
      end
    end
  end

  // Writes one register while the block is idle.
  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_GRID_ROWS) begin
      rows_q = clamp_dim(val);
      loaded_q = 0;
    end else if (idx == REG_GRID_COLS) begin
      cols_q = clamp_dim(val);
      loaded_q = 0;
    end
  endtask

  // Waits until every queued word is taken and every result has come.
  task automatic drain();
    while (land_words.size() > 0 || count_expected.size() > 0 || cells_ch.valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Queues grids of the current size; style is the land percent, or 0 for random.
  task automatic queue_grids(int unsigned n, int unsigned style);
    int unsigned pct;
    for (int g = 0; g < n; g++) begin
      pct = (style == 0) ? $urandom_range(0, 100) : style;
      for (int i = 0; i < rows_q * cols_q; i++)
        land_words.push_back($urandom_range(1, 100) <= pct);
    end
  endtask

  int unsigned total_words;
  initial begin
    rst = 1'b1;
    failures = 0;
    hold_result = 1'b0;
    driver_enable = 1'b1;
    rows_q = DEF_MAX_ROWS;
    cols_q = DEF_MAX_COLS;
    loaded_q = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.wdata = '0;
    result_ch.ready = 1'b0;
    cells_ch.valid = 1'b0;
    cells_ch.cell_is_land = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: single cell land and water, zero sizes, unknown index.
    write_reg(REG_GRID_ROWS, 7'd0);
    write_reg(REG_GRID_COLS, 7'd0);
    land_words.push_back(1'b1);
    land_words.push_back(1'b0);
    drain();
    write_reg(8'd2, 7'd5);
    write_reg(8'hFF, 7'h7F);
    // Oversized registers saturate; a write mid-load discards the partial grid.
    write_reg(REG_GRID_ROWS, 7'd2);
    write_reg(REG_GRID_COLS, 7'h7F);
    write_reg(REG_GRID_ROWS, 7'd3);
    write_reg(REG_GRID_COLS, 7'd4);
    land_words = '{1, 0, 1, 0, 1, 0, 1};
    drain();
    write_reg(REG_GRID_COLS, 7'd4);
    land_words = '{1, 0, 1, 0, 0, 1, 0, 1, 1, 0, 1, 0};
    land_words.push_back(1);
    for (int i = 0; i < 11; i++) land_words.push_back(1'b1);
    drain();

    // Full-width grid of eight rows, checkerboard.
    write_reg(REG_GRID_ROWS, 7'd8);
    write_reg(REG_GRID_COLS, 7'd64);
    for (int i = 0; i < 8 * 64; i++) land_words.push_back(((i / 64) + i) % 2);
    drain();

    // Random phases with small sizes; the receiver holds off in the first.
    total_words = 0;
    hold_result = 1'b1;
    write_reg(REG_GRID_ROWS, 7'd1);
    write_reg(REG_GRID_COLS, 7'd3);
    queue_grids(20, 0);
    repeat (300) @(posedge clk);
    hold_result = 1'b0;
    drain();
    while (total_words < 700) begin
      write_reg(REG_GRID_ROWS, 7'($urandom_range(0, 9)));
      write_reg(REG_GRID_COLS, 7'($urandom_range(0, 9)));
      queue_grids($urandom_range(2, 8), ($urandom_range(0, 3) == 0) ? 0 : 55);
      total_words += land_words.size();
      if ($urandom_range(0, 3) == 0) begin
        // Sender pauses part way until every expected result has come.
        repeat ($urandom_range(20, 200)) @(posedge clk);
        driver_enable = 1'b0;
        while (count_expected.size() > 0 || cells_ch.valid) @(posedge clk);
        driver_enable = 1'b1;
      end
      drain();
    end
    write_reg(REG_GRID_ROWS, 7'd1);
    write_reg(REG_GRID_COLS, 7'd64);
    queue_grids(2, 0);
    drain();
    repeat (50) @(posedge clk);

    if (failures == 0) begin
      $display("binary_grid_island_counter verification clean");
    end else begin
      $display("binary_grid_island_counter verification failed");
    end
    $finish;
  end

endmodule

/* binary_grid_island_counter.f */
rtl/bgic_pkg.sv
rtl/bgic_if.sv
rtl/bgic_ram.sv
rtl/binary_grid_island_counter.sv
rtl/bgic_checker.sv
tb/sv/tb_binary_grid_island_counter.sv
